[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/pba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  // request codes
  localparam logic [1:0] REQ_MARK  = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;

  localparam int unsigned PORT_W = 16;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PORT_W-1:0] port;
  } req_t;

  typedef struct packed {
    logic [PORT_W-1:0] granted_port;
    logic              alloc_failed;
  } res_t;

endpackage

`default_nettype wire

[src/port_bitmap_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port bitmap allocator: one occupancy bit per port, held in a synchronous RAM.
// Request channel: start with req_i; taken on a clock edge where start is high and
// busy is low. req_type selects mark used, mark free or allocate; a fourth code
// is a no-op. Result channel: res_valid_o pulses for one cycle with res_o; the
// receiver must take it then, there is no stall. Exactly one result per request.
// Mark / free: port split (reciprocal multiply, then correction), word read,
// read-modify-write; result appears after the split, read and write states,
// busy throughout (the write state is skipped when the port lies outside the map).
// Allocate: scans map words upward from a hint register (lowest word that may
// hold a free dynamic port), one RAM read per cycle, until a free port or the
// last word is reached. Rate is set by the single RAM read port.
// When the hint shows the dynamic range full, failure returns in the next cycle.
// A fresh request may be taken in the cycle its predecessor's result is shown.
// Reset: a clearing pass writes zero to every map word (MAP_WORDS words,
// 2048 at default), busy high throughout.
module port_bitmap_allocator_unit #(
  parameter int unsigned PORT_COUNT         = 65536,
  parameter int unsigned FIRST_DYNAMIC_PORT = 1024,
  parameter int unsigned WORD_BITS          = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire pba_pkg::req_t req_i,
  output logic               busy,
  output logic               res_valid_o,
  output pba_pkg::res_t      res_o
);
  import pba_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned MAP_WORDS  = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW        = $clog2(MAP_WORDS);
  localparam int unsigned HW         = $clog2(MAP_WORDS + 1);
  localparam int unsigned BW         = $clog2(WORD_BITS);
  localparam int unsigned FIRST_WORD = FIRST_DYNAMIC_PORT / WORD_BITS;
  localparam int unsigned FIRST_BIT  = FIRST_DYNAMIC_PORT % WORD_BITS;
  localparam bit          NO_DYN     = (FIRST_DYNAMIC_PORT >= PORT_COUNT);

  // hint at MAP_WORDS means no free dynamic port anywhere
  localparam logic [HW-1:0] HINT_FULL  = HW'(MAP_WORDS);
  localparam logic [HW-1:0] HINT_START = NO_DYN ? HINT_FULL : HW'(FIRST_WORD);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] FIRST_MASK = {WORD_BITS{1'b1}} << FIRST_BIT;
  localparam logic [PORT_W:0] PORT_LIMIT = (PORT_W + 1)'(PORT_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLIT,
    S_READ,
    S_RMW,
    S_SCAN
  } state_e;

  state_e         state_q;
  logic [WAW-1:0] clr_q;
  logic [HW-1:0]  hint_q;
  logic [WAW-1:0] scan_q;
  logic           set_q;
  logic           done_q;
  res_t           res_q;

  logic                 accept;
  logic                 split_load;
  logic [WAW-1:0]       word_s;
  logic [BW-1:0]        bit_s;
  logic                 in_range_s;

  logic                 rd_en;
  logic [WAW-1:0]       rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [BW-1:0]        free_idx;
  logic [PORT_W:0]      cand_port;
  logic                 cand_ok;
  logic [WORD_BITS-1:0] bit_mask;

  logic                 grant_shown;
  logic                 grant_dyn;

  assign accept     = start && !busy;
  assign split_load = accept && (req_i.req_type == REQ_MARK || req_i.req_type == REQ_FREE);

  pba_port_split #(
    .WORD_BITS (WORD_BITS),
    .PORT_COUNT(PORT_COUNT),
    .WAW       (WAW),
    .BW        (BW)
  ) u_split (
    .clk_i     (clk_i),
    .load_i    (split_load),
    .port_i    (req_i.port),
    .word_o    (word_s),
    .bit_o     (bit_s),
    .in_range_o(in_range_s)
  );

  pba_map_ram #(
    .WORD_BITS(WORD_BITS),
    .DEPTH    (MAP_WORDS),
    .AW       (WAW)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // only the first dynamic word has bits below the dynamic range
  assign free_bits = ~rd_data & ((HW'(scan_q) == HINT_START) ? FIRST_MASK
                                                               : {WORD_BITS{1'b1}});

  pba_first_free #(
    .WORD_BITS(WORD_BITS),
    .BW       (BW)
  ) u_ff (
    .free_i (free_bits),
    .found_o(found),
    .idx_o  (free_idx)
  );

  // candidate port; a hit past PORT_COUNT in a partial last word is a failure
  assign cand_port = (PORT_W + 1)'(scan_q * WORD_BITS) + (PORT_W + 1)'(free_idx);
  assign cand_ok   = found && (cand_port < PORT_LIMIT);
  assign bit_mask  = WORD_BITS'(1) << bit_s;

  // RAM port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = word_s;
    wr_en   = 1'b0;
    wr_addr = word_s;
    wr_data = set_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      S_IDLE: begin
        if (accept && req_i.req_type == REQ_ALLOC && hint_q != HINT_FULL) begin
          rd_en   = 1'b1;
          rd_addr = hint_q[WAW-1:0];
        end
      end
      S_READ: begin
        rd_en = in_range_s;
      end
      S_RMW: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        if (cand_ok) begin
          wr_en   = 1'b1;
          wr_addr = scan_q;
          wr_data = rd_data | (WORD_BITS'(1) << free_idx);
        end else if (!found && scan_q != LAST_WORD) begin
          rd_en   = 1'b1;
          rd_addr = scan_q + WAW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      hint_q  <= HINT_START;
      scan_q  <= '0;
      set_q   <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          done_q <= 1'b0;
          clr_q  <= clr_q + WAW'(1);
          if (clr_q == LAST_WORD) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req_i.req_type)
              REQ_MARK, REQ_FREE: begin
                res_q   <= '0;
                done_q  <= 1'b0;
                set_q   <= (req_i.req_type == REQ_MARK);
                state_q <= S_SPLIT;
              end
              REQ_ALLOC: begin
                if (hint_q == HINT_FULL) begin
                  res_q  <= '{granted_port: '0, alloc_failed: 1'b1};
                  done_q <= 1'b1;
                end else begin
                  res_q   <= '0;
                  done_q  <= 1'b0;
                  scan_q  <= hint_q[WAW-1:0];
                  state_q <= S_SCAN;
                end
              end
              default: begin
                res_q  <= '0;
                done_q <= 1'b1;
              end
            endcase
          end else begin
            done_q <= 1'b0;
          end
        end
        S_SPLIT: begin
          done_q  <= 1'b0;
          state_q <= S_READ;
        end
        S_READ: begin
          if (in_range_s) begin
            done_q  <= 1'b0;
            state_q <= S_RMW;
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_RMW: begin
          // a free below the hint reopens the scan there
          if (!set_q && HW'(word_s) >= HINT_START && HW'(word_s) < hint_q) begin
            hint_q <= HW'(word_s);
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (cand_ok) begin
            hint_q  <= HW'(scan_q);
            res_q   <= '{granted_port: cand_port[PORT_W-1:0], alloc_failed: 1'b0};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (found || scan_q == LAST_WORD) begin
            hint_q  <= HINT_FULL;
            res_q   <= '{granted_port: '0, alloc_failed: 1'b1};
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            done_q <= 1'b0;
            scan_q <= scan_q + WAW'(1);
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = done_q;
  assign res_o       = res_q;

  // grants always lie in the dynamic range
  assign grant_shown = done_q && res_q.granted_port != '0;
  assign grant_dyn   = (PORT_W + 1)'(res_q.granted_port) >= (PORT_W + 1)'(FIRST_DYNAMIC_PORT);

  `ASSERT_IMP(a_fail_no_port, clk_i, rst_ni, done_q && res_q.alloc_failed, res_q.granted_port == '0)
  `ASSERT_IMP(a_grant_dynamic, clk_i, rst_ni, grant_shown, grant_dyn)
  `ASSERT_NXT(a_mark_busy, clk_i, rst_ni, split_load, busy && !done_q)
  `ASSERT_IMP(a_hint_bound, clk_i, rst_ni, 1'b1, hint_q <= HINT_FULL)

endmodule

`default_nettype wire

[src/pba_map_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pba_map_ram #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned DEPTH     = 2048,
  parameter int unsigned AW        = 11
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic      [WORD_BITS-1:0] rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic [WORD_BITS-1:0] wr_data_i
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[src/pba_port_split.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port number -> (word, bit) by reciprocal multiply and one correction step.
module pba_port_split #(
  parameter int unsigned WORD_BITS  = 32,
  parameter int unsigned PORT_COUNT = 65536,
  parameter int unsigned WAW        = 11,
  parameter int unsigned BW         = 5
) (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic [pba_pkg::PORT_W-1:0]  port_i,
  output logic      [WAW-1:0]              word_o,
  output logic      [BW-1:0]               bit_o,
  output logic                             in_range_o
);
  import pba_pkg::*;

  localparam int unsigned SHIFT   = 24;
  localparam int unsigned RECIP_W = 22;
  localparam int unsigned PROD_W  = PORT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / WORD_BITS);

  logic [PROD_W-1:0]   prod_q;
  logic [PORT_W-1:0]   port_q;
  logic [PORT_W-1:0]   q0;
  logic [PORT_W:0]     r0;
  logic                corr;
  logic [PORT_W-1:0]   word_d;
  logic [PORT_W:0]     rem_d;
  logic [WAW-1:0]      word_q;
  logic [BW-1:0]       bit_q;
  logic                in_range_q;

  // stage 1: product only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PROD_W'(port_i) * PROD_W'(RECIP);
      port_q <= port_i;
    end
  end

  // estimate is exact or one low
  always_comb begin
    q0     = prod_q[PROD_W-1:SHIFT];
    r0     = (PORT_W + 1)'(port_q) - (PORT_W + 1)'(q0 * WORD_BITS);
    corr   = (r0 >= (PORT_W + 1)'(WORD_BITS));
    word_d = q0 + PORT_W'(corr);
    rem_d  = corr ? (r0 - (PORT_W + 1)'(WORD_BITS)) : r0;
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    word_q     <= word_d[WAW-1:0];
    bit_q      <= rem_d[BW-1:0];
    in_range_q <= ((PORT_W + 1)'(port_q) < (PORT_W + 1)'(PORT_COUNT));
  end

  assign word_o     = word_q;
  assign bit_o      = bit_q;
  assign in_range_o = in_range_q;

endmodule

`default_nettype wire

[src/pba_first_free.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lowest set bit of a word of free bits.
module pba_first_free #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned BW        = 5
) (
  input  wire logic [WORD_BITS-1:0] free_i,
  output logic                      found_o,
  output logic      [BW-1:0]        idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        idx_o = BW'(i);
      end
    end
  end

  assign found_o = |free_i;

endmodule

`default_nettype wire
